### rtl/lfbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lfbc_pkg;

   typedef enum logic [1:0] {
      MODE_TICK  = 2'd0,
      MODE_FLASH = 2'd1,
      MODE_BLINK = 2'd2,
      MODE_OFF   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_BRIGHTNESS    = 2'd0,
      CSR_PULSE_ON_MS   = 2'd1,
      CSR_PULSE_OFF_MS  = 2'd2,
      CSR_REPEAT_GAP_MS = 2'd3
   } csr_index_type;

   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned ELAPSED_W   = 18;
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
   localparam logic [7:0]  LEVEL_FULL_ON = 8'hFF;

   localparam logic [7:0]  BRIGHTNESS_RST    = 8'd255;
   localparam logic [15:0] PULSE_ON_MS_RST   = 16'd100;
   localparam logic [15:0] PULSE_OFF_MS_RST  = 16'd100;
   localparam logic [15:0] REPEAT_GAP_MS_RST = 16'd1000;

   typedef struct packed {
      mode_type    mode;
      logic [15:0] flash_time;
      logic [7:0]  pulse_count;
      logic        repeat_forever;
   } req_type;

   typedef struct packed {
      logic [7:0] led_level;
      logic       is_active;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  brightness;
      logic [15:0] pulse_on_ms;
      logic [15:0] pulse_off_ms;
      logic [15:0] repeat_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic                 running;
      logic [ELAPSED_W-1:0] elapsed_ms;
      logic [15:0]          flash_limit;
      logic [7:0]           group_size;
      logic [7:0]           pulses_left;
      logic                 repeat_mode;
      logic [7:0]           drive_level;
   } state_type;

endpackage
`default_nettype wire

### rtl/led_flash_blink_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none
// LED flash/blink controller. Each accepted item (a 1 ms tick or a flash, blink
// or off command) is applied to the pattern state in the cycle it is accepted,
// and its result (LED level and active flag) appears in the output register on
// the next cycle. The combinational state update and the output register let
// one item be accepted every cycle while req_ready is high, which holds as long
// as the output register is empty or being drained in the same cycle. CSR writes
// apply to items accepted after them; a running flash keeps its lit level.
module led_flash_blink_controller_core #(
   parameter int unsigned FULL_LEVEL = 255
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire lfbc_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output lfbc_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_we,
   input  wire lfbc_pkg::csr_index_type         csr_index,
   input  wire logic [lfbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   lfbc_pkg::cfg_type   cfg;
   lfbc_pkg::state_type state_ff;
   lfbc_pkg::state_type state_in;
   lfbc_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                accept;

   lfbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lfbc_step #(
      .FULL_LEVEL (FULL_LEVEL)
   ) u_step (
      .req (req_data),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_in)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff.led_level <= state_in.drive_level;
         rsp_ff.is_active <= state_in.running;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      !state_ff.running |-> state_ff.drive_level == 8'd0)
      else $error("drive level nonzero while no pattern runs");

   a_pulses_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.pulses_left <= state_ff.group_size)
      else $error("pulses left exceeds group size");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_ff.is_active == state_ff.running &&
                 rsp_ff.led_level == state_ff.drive_level)
      else $error("result does not match updated state");
`endif

endmodule
`default_nettype wire

### rtl/lfbc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
module lfbc_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire lfbc_pkg::csr_index_type         csr_index,
   input  wire logic [lfbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lfbc_pkg::cfg_type                    cfg
);

   lfbc_pkg::cfg_type cfg_ff;
   lfbc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            lfbc_pkg::CSR_BRIGHTNESS:    cfg_in.brightness    = csr_wdata[7:0];
            lfbc_pkg::CSR_PULSE_ON_MS:   cfg_in.pulse_on_ms   = csr_wdata[15:0];
            lfbc_pkg::CSR_PULSE_OFF_MS:  cfg_in.pulse_off_ms  = csr_wdata[15:0];
            lfbc_pkg::CSR_REPEAT_GAP_MS: cfg_in.repeat_gap_ms = csr_wdata[15:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.brightness    <= lfbc_pkg::BRIGHTNESS_RST;
         cfg_ff.pulse_on_ms   <= lfbc_pkg::PULSE_ON_MS_RST;
         cfg_ff.pulse_off_ms  <= lfbc_pkg::PULSE_OFF_MS_RST;
         cfg_ff.repeat_gap_ms <= lfbc_pkg::REPEAT_GAP_MS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### rtl/lfbc_step.sv
`timescale 1ns / 1ps
`default_nettype none
module lfbc_step #(
   parameter int unsigned FULL_LEVEL = 255
) (
   input  wire lfbc_pkg::req_type   req,
   input  wire lfbc_pkg::cfg_type   cfg,
   input  wire lfbc_pkg::state_type cur,
   output lfbc_pkg::state_type      nxt
);

   localparam logic [7:0] FullLvl = 8'(FULL_LEVEL);

   logic [7:0]                     lit_level;
   logic [lfbc_pkg::ELAPSED_W-1:0] elapsed_inc;
   logic [16:0]                    period_ms;

   always_comb begin
      lit_level   = (cfg.brightness < FullLvl) ? cfg.brightness : lfbc_pkg::LEVEL_FULL_ON;
      elapsed_inc = cur.elapsed_ms +
                    lfbc_pkg::ELAPSED_W'(cur.elapsed_ms != lfbc_pkg::ELAPSED_MAX);
      period_ms   = {1'b0, cfg.pulse_on_ms} + {1'b0, cfg.pulse_off_ms};
   end

   always_comb begin
      nxt = cur;
      case (req.mode)
         lfbc_pkg::MODE_TICK: begin
            if (cur.running) begin
               nxt.elapsed_ms = elapsed_inc;
               if (cur.pulses_left != 8'd0) begin
                  if (elapsed_inc < {2'b00, cfg.pulse_on_ms}) begin
                     nxt.drive_level = lit_level;
                  end else begin
                     nxt.drive_level = 8'd0;
                     // end of one on/off pulse
                     if (elapsed_inc > {1'b0, period_ms}) begin
                        nxt.elapsed_ms  = '0;
                        nxt.pulses_left = cur.pulses_left - 8'd1;
                        if (cur.pulses_left == 8'd1 && !cur.repeat_mode) begin
                           nxt.running = 1'b0;
                        end
                     end
                  end
               end else if (cur.group_size != 8'd0 && cur.repeat_mode) begin
                  // cooldown over: relight and reload the group
                  if (elapsed_inc > {2'b00, cfg.repeat_gap_ms}) begin
                     nxt.elapsed_ms  = '0;
                     nxt.pulses_left = cur.group_size;
                     nxt.drive_level = lit_level;
                  end
               end else if (cur.flash_limit != 16'd0 &&
                            elapsed_inc >= {2'b00, cur.flash_limit}) begin
                  nxt.running     = 1'b0;
                  nxt.drive_level = 8'd0;
               end
            end
         end
         lfbc_pkg::MODE_FLASH: begin
            if (!(cur.running && cur.group_size == 8'd0)) begin
               nxt.running     = 1'b1;
               nxt.elapsed_ms  = '0;
               nxt.flash_limit = req.flash_time;
               nxt.group_size  = 8'd0;
               nxt.pulses_left = 8'd0;
               nxt.repeat_mode = 1'b0;
               nxt.drive_level = lit_level;
            end
         end
         lfbc_pkg::MODE_BLINK: begin
            if (cur.running && req.pulse_count == 8'd0) begin
               nxt.running     = 1'b0;
               nxt.drive_level = 8'd0;
            end else if (cur.running && cur.group_size != 8'd0) begin
               nxt.repeat_mode = req.repeat_forever;
               nxt.group_size  = req.pulse_count;
               if (cur.pulses_left > req.pulse_count) begin
                  nxt.pulses_left = req.pulse_count;
               end
            end else begin
               nxt.running     = 1'b1;
               nxt.elapsed_ms  = '0;
               nxt.flash_limit = 16'd0;
               nxt.group_size  = req.pulse_count;
               nxt.pulses_left = req.pulse_count;
               nxt.repeat_mode = req.repeat_forever;
               nxt.drive_level = lit_level;
            end
         end
         lfbc_pkg::MODE_OFF: begin
            if (cur.running) begin
               nxt.running     = 1'b0;
               nxt.drive_level = 8'd0;
            end
         end
         default: nxt = cur;
      endcase
   end

endmodule
`default_nettype wire

### tb/led_blink_checker.sv
`timescale 1ns / 1ps
module led_blink_checker #(
   parameter int unsigned FULL_LEVEL = 255
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire lfbc_pkg::req_type               req_data,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire lfbc_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_we,
   input  wire lfbc_pkg::csr_index_type         csr_index,
   input  wire logic [lfbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                          pending_count,
   output int unsigned                          fail_count
);
   import lfbc_pkg::*;

   cfg_type   settings;
   state_type led;
   rsp_type   expected_levels[$];

   initial begin
      pending_count = 0;
      fail_count    = 0;
   end

   function automatic logic [7:0] lit_level(input logic lit);
      if (!lit) return 8'd0;
      if (settings.brightness < FULL_LEVEL) return settings.brightness;
      return LEVEL_FULL_ON;
   endfunction

   function automatic void stop_pattern();
      if (led.running) begin
         led.running     = 1'b0;
         led.drive_level = 8'd0;
      end
   endfunction

   function automatic void advance_ms();
      int unsigned cycle_ms;
      cycle_ms = settings.pulse_on_ms + settings.pulse_off_ms;
      if (!led.running) return;
      if (led.elapsed_ms != ELAPSED_MAX) led.elapsed_ms = led.elapsed_ms + 1'b1;
      if (led.pulses_left != 0) begin
         if (led.elapsed_ms < settings.pulse_on_ms) begin
            led.drive_level = lit_level(1'b1);
         end else begin
            led.drive_level = 8'd0;
            if (led.elapsed_ms > cycle_ms) begin
               led.elapsed_ms  = '0;
               led.pulses_left = led.pulses_left - 1'b1;
               if (led.pulses_left == 0 && !led.repeat_mode) stop_pattern();
            end
         end
      end else if (led.group_size != 0 && led.repeat_mode) begin
         // cooldown over: relight with a full group
         if (led.elapsed_ms > settings.repeat_gap_ms) begin
            led.elapsed_ms  = '0;
            led.pulses_left = led.group_size;
            led.drive_level = lit_level(1'b1);
         end
      end else if (led.flash_limit != 0 && led.elapsed_ms >= led.flash_limit) begin
         stop_pattern();
      end
   endfunction

   function automatic void start_flash(input logic [15:0] duration);
      if (led.running && led.group_size == 0) return;
      led.running     = 1'b1;
      led.elapsed_ms  = '0;
      led.flash_limit = duration;
      led.group_size  = 8'd0;
      led.pulses_left = 8'd0;
      led.repeat_mode = 1'b0;
      led.drive_level = lit_level(1'b1);
   endfunction

   function automatic void start_blink(input logic [7:0] count, input logic repeating);
      if (led.running && count == 0) begin
         stop_pattern();
      end else if (led.running && led.group_size != 0) begin
         // retune a running blink, timing untouched
         led.repeat_mode = repeating;
         led.group_size  = count;
         if (led.pulses_left > count) led.pulses_left = count;
      end else begin
         led.running     = 1'b1;
         led.elapsed_ms  = '0;
         led.flash_limit = 16'd0;
         led.group_size  = count;
         led.pulses_left = count;
         led.repeat_mode = repeating;
         led.drive_level = lit_level(1'b1);
      end
   endfunction

   function automatic rsp_type next_level(input req_type item);
      rsp_type level;
      case (item.mode)
         MODE_TICK:  advance_ms();
         MODE_FLASH: start_flash(item.flash_time);
         MODE_BLINK: start_blink(item.pulse_count, item.repeat_forever);
         default:    stop_pattern();
      endcase
      level.led_level = led.drive_level;
      level.is_active = led.running;
      return level;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         settings.brightness    = BRIGHTNESS_RST;
         settings.pulse_on_ms   = PULSE_ON_MS_RST;
         settings.pulse_off_ms  = PULSE_OFF_MS_RST;
         settings.repeat_gap_ms = REPEAT_GAP_MS_RST;
         led = '0;
         expected_levels.delete();
      end else begin
         // check the result first: it belongs to an older item
         if (rsp_valid && rsp_ready) begin
            if (expected_levels.size() == 0) begin
               $display("%0t: unexpected item: led_level %0d is_active %0b",
                        $time, rsp_data.led_level, rsp_data.is_active);
               fail_count = fail_count + 1;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_data.led_level !== want.led_level) begin
                  $display("%0t: led_level expected %0d actual %0d",
                           $time, want.led_level, rsp_data.led_level);
                  fail_count = fail_count + 1;
               end
               if (rsp_data.is_active !== want.is_active) begin
                  $display("%0t: is_active expected %0b actual %0b",
                           $time, want.is_active, rsp_data.is_active);
                  fail_count = fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) expected_levels.push_back(next_level(req_data));
         // a register write lands after any item taken at the same edge
         if (csr_we) begin
            case (csr_index)
               CSR_BRIGHTNESS:    settings.brightness    = csr_wdata[7:0];
               CSR_PULSE_ON_MS:   settings.pulse_on_ms   = csr_wdata;
               CSR_PULSE_OFF_MS:  settings.pulse_off_ms  = csr_wdata;
               CSR_REPEAT_GAP_MS: settings.repeat_gap_ms = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_levels.size();
   end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import lfbc_pkg::*;

   localparam int unsigned STALL_LIMIT = 1000;
   localparam int unsigned PHASES      = 13;
   localparam int unsigned PHASE_ITEMS = 100;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   csr_index_type         csr_index = CSR_BRIGHTNESS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int unsigned pending_count;
   int unsigned fail_count;
   int unsigned idle_cycles = 0;
   int unsigned rsp_stall   = 0;
   logic        rsp_taken   = 1'b0;
   bit          quiet       = 1'b0;
   bit          no_gaps     = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   led_flash_blink_controller_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   led_blink_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .pending_count (pending_count),
      .fail_count    (fail_count)
   );

   function automatic int unsigned draw_gap();
      if (no_gaps || quiet) return 0;
      return $urandom_range(0, 7);
   endfunction

   // result side: hold ready low for a fresh draw of cycles after each item
   always @(posedge clock) rsp_taken <= rsp_valid && rsp_ready;

   always @(negedge clock) begin
      if (rsp_taken) rsp_stall = draw_gap();
      if (rsp_stall != 0) begin
         rsp_ready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_item(input mode_type mode, input logic [15:0] duration,
                                         input logic [7:0] count, input logic repeating);
      req_type item;
      item.mode           = mode;
      item.flash_time     = duration;
      item.pulse_count    = count;
      item.repeat_forever = repeating;
      return item;
   endfunction

   function automatic req_type noise_tick();
      return make_item(MODE_TICK, 16'($urandom_range(0, 65535)),
                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endfunction

   function automatic logic [15:0] pick_duration();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 16'd0;
      if (pick == 1) return 16'hFFFF;
      if (pick == 2) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, 6));
   endfunction

   // mostly ticks so patterns run through their phases, commands mixed in
   function automatic req_type random_item();
      req_type     item;
      int unsigned pick;
      item = noise_tick();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         item.mode = MODE_TICK;
      end else if (pick < 78) begin
         item.mode = MODE_FLASH;
         if ($urandom_range(0, 3) != 0) item.flash_time = 16'($urandom_range(0, 8));
      end else if (pick < 95) begin
         item.mode = MODE_BLINK;
         if ($urandom_range(0, 4) != 0) item.pulse_count = 8'($urandom_range(0, 4));
      end else begin
         item.mode = MODE_OFF;
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type index, input logic [15:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic load_settings(input logic [15:0] level, input logic [15:0] on_ms,
                                input logic [15:0] off_ms, input logic [15:0] gap_ms);
      drain_results();
      write_register(CSR_BRIGHTNESS, level);
      write_register(CSR_PULSE_ON_MS, on_ms);
      write_register(CSR_PULSE_OFF_MS, off_ms);
      write_register(CSR_REPEAT_GAP_MS, gap_ms);
   endtask

   initial begin : stimulus
      int unsigned phase;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: flash and blink command interplay
      send_item(make_item(MODE_OFF, 16'hFFFF, 8'hFF, 1'b1));
      send_item(make_item(MODE_TICK, 16'h0000, 8'h00, 1'b0));
      send_item(make_item(MODE_FLASH, 16'h0000, 8'h00, 1'b0));
      send_item(make_item(MODE_FLASH, 16'hFFFF, 8'h00, 1'b0));
      send_item(make_item(MODE_BLINK, 16'h0000, 8'h00, 1'b1));
      send_item(make_item(MODE_BLINK, 16'hFFFF, 8'h00, 1'b0));
      send_item(make_item(MODE_BLINK, 16'h0000, 8'hFF, 1'b1));
      send_item(make_item(MODE_BLINK, 16'h0000, 8'h03, 1'b0));
      send_item(make_item(MODE_OFF, 16'h0000, 8'h00, 1'b0));

      // short timing: one repeating group, then drop to once in the cooldown
      load_settings(16'd37, 16'd2, 16'd1, 16'd3);
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd2, 1'b1));
      repeat (9) send_item(noise_tick());
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd2, 1'b0));
      repeat (2) send_item(noise_tick());
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd1, 1'b1));
      send_item(noise_tick());
      send_item(make_item(MODE_FLASH, 16'd3, 8'h00, 1'b0));
      repeat (4) send_item(noise_tick());

      // park dark in the cooldown for a while, switch back to repeating, then stop
      load_settings(16'd37, 16'd2, 16'd1, 16'hFFFF);
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd1, 1'b1));
      repeat (4) send_item(noise_tick());
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd1, 1'b0));
      no_gaps = 1'b1;
      repeat (40) send_item(noise_tick());
      no_gaps = 1'b0;
      send_item(make_item(MODE_BLINK, 16'h0000, 8'd1, 1'b1));
      send_item(noise_tick());
      send_item(make_item(MODE_OFF, 16'h0000, 8'h00, 1'b0));

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       load_settings(16'd0, 16'd0, 16'd0, 16'd0);
            1:       load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2:       load_settings(16'd254, 16'd1, 16'd0, 16'd1);
            default: load_settings(16'($urandom_range(0, 65535)), pick_duration(),
                                   pick_duration(), pick_duration());
         endcase
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(0, 49) == 0) quiet = !quiet;
            send_item(random_item());
         end
      end

      quiet = 1'b0;
      drain_results();
      repeat (4) @(negedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
